>>> hdl/absc_pkg.sv
package absc_pkg;

  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 8;
  localparam int ACCEL_W  = 13;
  localparam int STREN_W  = 14;
  localparam int MINMS_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 48;

  localparam logic [ACCEL_W:0]   GRAVITY_UNITS = 14'sd256;
  localparam logic [LEVEL_W-1:0] RAMP_STEP     = 8'd2;

  localparam logic [TIME_W-1:0]  ACTIVE_TIMEOUT_RST = 32'd8000;
  localparam logic [LEVEL_W-1:0] ACTIVE_LEVEL_RST   = 8'd200;
  localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RST     = 8'd20;
  localparam logic [STREN_W-1:0] SHAKE_THRESH_RST   = 14'd717;
  localparam logic [MINMS_W-1:0] SHAKE_MIN_RST      = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_TIMEOUT = 3'd0,
    REG_ACTIVE_LEVEL   = 3'd1,
    REG_IDLE_LEVEL     = 3'd2,
    REG_SHAKE_THRESH   = 3'd3,
    REG_SHAKE_MIN      = 3'd4
  } reg_idx_t;

  typedef enum logic [IN_USER_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_TOUCH  = 2'd1,
    MODE_SAMPLE = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
    logic                      sample_fresh;
    logic                      shake_enabled;
  } in_item_t;

endpackage

>>> hdl/activity_brightness_shake_controller.sv
// Activity brightness and shake controller. Each input word is one timestamped event
// (tuser selects brightness tick, user interaction or accelerometer sample) and yields
// exactly one result word holding the backlight level, the active flag, a scare pulse
// and the running shake duration. An event is registered on entry, evaluated by one
// pass of compare and add logic against the held state, and the result is written to
// an output register; a new word is taken every cycle while the output register is
// free or being drained, so throughput is one event per clock. The user must write
// configuration registers via the cfg port only while idle; the block does not check
// this. A new active or idle level takes effect at the next tick or interaction.
module activity_brightness_shake_controller import absc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // now_ms[31:0], accel_x[44:32], accel_y[57:45], accel_z[70:58],
  // sample_fresh[71], shake_enabled[72], zero fill
  input  logic [IN_DATA_W-1:0]     in_tdata,
  // mode[1:0]
  input  logic [IN_USER_W-1:0]     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // level[7:0], display_on[8], scare_pulse[9], shake_time_ms[41:10], zero fill
  output logic [OUT_DATA_W-1:0]    out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DAT_W-1:0]     cfg_data
);

  logic [TIME_W-1:0]  active_timeout_r;
  logic [LEVEL_W-1:0] active_level_r;
  logic [LEVEL_W-1:0] idle_level_r;
  logic [STREN_W-1:0] shake_thresh_r;
  logic [MINMS_W-1:0] shake_min_r;

  logic               s1_valid_r;
  logic [IN_USER_W-1:0] s1_mode_r;
  in_item_t           s1_item_r;

  logic [TIME_W-1:0]  last_touch_r, last_touch_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               active_r, active_nxt;
  logic               running_r, running_nxt;
  logic [TIME_W-1:0]  begin_r, begin_nxt;
  logic [TIME_W-1:0]  len_r, len_nxt;
  logic               scare_nxt;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic               advance;
  logic [TIME_W-1:0]  idle_time;
  logic               act;
  logic [LEVEL_W-1:0] target;
  logic [LEVEL_W:0]   target_ramp;
  logic [ACCEL_W:0]   z_off;
  logic [ACCEL_W-1:0] mag_x, mag_y;
  logic [ACCEL_W:0]   mag_z;
  logic [STREN_W-1:0] strength;
  logic               hit;
  logic [TIME_W-1:0]  start_ms;

  assign cfg_ready  = 1'b1;
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_timeout_r <= ACTIVE_TIMEOUT_RST;
      active_level_r   <= ACTIVE_LEVEL_RST;
      idle_level_r     <= IDLE_LEVEL_RST;
      shake_thresh_r   <= SHAKE_THRESH_RST;
      shake_min_r      <= SHAKE_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ACTIVE_TIMEOUT: active_timeout_r <= cfg_data;
        REG_ACTIVE_LEVEL:   active_level_r   <= cfg_data[LEVEL_W-1:0];
        REG_IDLE_LEVEL:     idle_level_r     <= cfg_data[LEVEL_W-1:0];
        REG_SHAKE_THRESH:   shake_thresh_r   <= cfg_data[STREN_W-1:0];
        REG_SHAKE_MIN:      shake_min_r      <= cfg_data[MINMS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tuser;
      s1_item_r <= {in_tdata[31:0], in_tdata[44:32], in_tdata[57:45], in_tdata[70:58],
                    in_tdata[71], in_tdata[72]};
    end
  end

  always_comb begin
    idle_time   = s1_item_r.now_ms - last_touch_r;
    act         = idle_time < active_timeout_r;
    target      = act ? active_level_r : idle_level_r;
    target_ramp = {1'b0, target} + {1'b0, RAMP_STEP};

    mag_x    = s1_item_r.accel_x[ACCEL_W-1] ? ACCEL_W'(-s1_item_r.accel_x)
                                             : s1_item_r.accel_x;
    mag_y    = s1_item_r.accel_y[ACCEL_W-1] ? ACCEL_W'(-s1_item_r.accel_y)
                                             : s1_item_r.accel_y;
    z_off    = {s1_item_r.accel_z[ACCEL_W-1], s1_item_r.accel_z} - GRAVITY_UNITS;
    mag_z    = z_off[ACCEL_W] ? (ACCEL_W+1)'(-z_off) : z_off;
    strength = STREN_W'({1'b0, mag_x}) + STREN_W'({1'b0, mag_y}) + STREN_W'(mag_z);
    hit      = s1_item_r.shake_enabled && s1_item_r.sample_fresh
               && (strength > shake_thresh_r);
    start_ms = running_r ? begin_r : s1_item_r.now_ms;

    last_touch_nxt = last_touch_r;
    level_nxt      = level_r;
    active_nxt     = active_r;
    running_nxt    = running_r;
    begin_nxt      = begin_r;
    len_nxt        = len_r;
    scare_nxt      = 1'b0;

    case (s1_mode_r)
      MODE_TICK: begin
        active_nxt = act;
        if (level_r < target) begin
          level_nxt = target;
        end else if (level_r > target) begin
          level_nxt = ({1'b0, level_r} > target_ramp) ? level_r - RAMP_STEP : target;
        end
      end
      MODE_TOUCH: begin
        last_touch_nxt = s1_item_r.now_ms;
        active_nxt     = 1'b1;
        level_nxt      = active_level_r;
      end
      MODE_SAMPLE: begin
        if (hit) begin
          running_nxt = 1'b1;
          begin_nxt   = start_ms;
          len_nxt     = s1_item_r.now_ms - start_ms;
        end else begin
          if ((len_r != '0) && (len_r > {{(TIME_W-MINMS_W){1'b0}}, shake_min_r})) begin
            last_touch_nxt = s1_item_r.now_ms;
            active_nxt     = 1'b1;
            level_nxt      = active_level_r;
            scare_nxt      = 1'b1;
          end
          running_nxt = 1'b0;
          begin_nxt   = '0;
          len_nxt     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_touch_r <= '0;
      level_r      <= ACTIVE_LEVEL_RST;
      active_r     <= 1'b1;
      running_r    <= 1'b0;
      begin_r      <= '0;
      len_r        <= '0;
    end else if (advance) begin
      last_touch_r <= last_touch_nxt;
      level_r      <= level_nxt;
      active_r     <= active_nxt;
      running_r    <= running_nxt;
      begin_r      <= begin_nxt;
      len_r        <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'b0, len_nxt, scare_nxt, active_nxt, level_nxt};
    end
  end

  a_scare_ends_shake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[9]) |-> (out_data_r[41:10] == '0 && out_data_r[8]))
    else $error("scare pulse without cleared shake or active display");

  a_idle_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (len_r == '0 && begin_r == '0))
    else $error("shake length held while no shake is running");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty entry stage");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated event did not reach output register");

endmodule
